FILE: sv/tkbt_pkg.sv
// Shared types and constants of the touch key baseline tracker.
`default_nettype none

package tkbt_pkg;

  localparam int unsigned BASE_W  = 16;
  localparam int unsigned PHASE_W = 5;
  localparam int unsigned KEY_W   = 4;
  localparam int unsigned AVG_W   = 4;

  localparam logic [BASE_W-1:0] RISE_STEP = 16'd5;
  localparam logic [BASE_W-1:0] BASE_MAX  = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_INIT_AVG  = 2'd1;

  localparam logic [BASE_W-1:0] THRESHOLD_RST = 16'd100;
  localparam logic [AVG_W-1:0]  INIT_AVG_RST  = 4'd4;

  // One stored entry per key: calibration phase and baseline.
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [BASE_W-1:0]  baseline;
  } entry_t;

  // Result of one key update.
  typedef struct packed {
    logic              calibrating;
    logic [BASE_W-1:0] new_baseline;
    logic [BASE_W-1:0] key_delta;
    logic              touched;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/tkbt_update.sv
// Combinational update of one key entry from one oscillator count.
`default_nettype none

module tkbt_update (
  input  tkbt_pkg::entry_t                 cur,
  input  logic [tkbt_pkg::BASE_W-1:0]      sample,
  input  logic [tkbt_pkg::BASE_W-1:0]      threshold,
  input  logic [tkbt_pkg::AVG_W-1:0]       init_avg,
  output tkbt_pkg::entry_t                 nxt,
  output tkbt_pkg::result_t                res
);

  logic [tkbt_pkg::PHASE_W-1:0] phase_m1;
  logic [tkbt_pkg::BASE_W:0]    rise_sum;
  logic [tkbt_pkg::BASE_W-1:0]  b_track;
  logic [tkbt_pkg::BASE_W-1:0]  delta;
  logic                         hit;

  assign phase_m1 = cur.phase - tkbt_pkg::PHASE_W'(1);
  assign rise_sum = {1'b0, cur.baseline} + {1'b0, tkbt_pkg::RISE_STEP};

  // Tracking phase: the baseline rises by a fixed step (saturating) when the count
  // is not below it, and then decays by one, unless zero, whenever the key is not touched.
  always_comb begin
    if (sample < cur.baseline) begin
      delta   = cur.baseline - sample;
      b_track = cur.baseline;
    end else begin
      delta   = '0;
      b_track = rise_sum[tkbt_pkg::BASE_W] ? tkbt_pkg::BASE_MAX
                                           : rise_sum[tkbt_pkg::BASE_W-1:0];
    end
    hit = (delta > threshold);
    if (!hit && (b_track != '0)) begin
      b_track = b_track - tkbt_pkg::BASE_W'(1);
    end
  end

  always_comb begin
    priority if (cur.phase == '0) begin
      // Seeding sample.
      nxt.phase        = tkbt_pkg::PHASE_W'(1);
      nxt.baseline     = sample;
      res.touched      = 1'b0;
      res.key_delta    = '0;
      res.calibrating  = 1'b1;
    end else if (phase_m1 < {1'b0, init_avg}) begin
      // Averaging sample.
      nxt.phase        = cur.phase + tkbt_pkg::PHASE_W'(1);
      nxt.baseline     = (cur.baseline >> 1) + (sample >> 1);
      res.touched      = 1'b0;
      res.key_delta    = '0;
      res.calibrating  = 1'b1;
    end else begin
      nxt.phase        = cur.phase;
      nxt.baseline     = b_track;
      res.touched      = hit;
      res.key_delta    = delta;
      res.calibrating  = 1'b0;
    end
    res.new_baseline = nxt.baseline;
  end

endmodule

`default_nettype wire

FILE: sv/touch_key_baseline_tracker_core.sv
// Top level of the touch key baseline tracker: key memory, pipeline and ports.
`default_nettype none

// Channel  | Ports                          | Contents
// ---------+--------------------------------+-----------------------------------------
// in       | in_tvalid/in_tready            | tuser: key index, tdata: oscillator count
// out      | out_tvalid/out_tready          | tuser: key index, tdata: flags, delta, base
// cfg      | cfg_we, cfg_index, cfg_wdata   | threshold, averaging sample count
//
// The block takes one item per cycle while the output is not stalled. The rate
// is set by the read-modify-write of one key entry in the key memory: the read
// is issued when the item is accepted, the update and write-back happen when
// the item leaves the update stage, and a bypass register forwards a write to
// a read of the same key issued at the same edge. rst_n is synchronous and
// clears the pipeline, the registers and the per-key valid bits, so every key
// reads as unseeded after reset with no clearing pass. A stalled output holds
// its item while one more item waits in the update stage. Items whose key index
// lies beyond the number of keys are accepted and dropped without a result.

module touch_key_baseline_tracker_core #(
  parameter int unsigned NUM_KEYS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] measured_count
  input  logic [3:0]  in_tuser,   // [3:0] key_index
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [0] touched, [16:1] key_delta,
                                  // [32:17] new_baseline, [33] calibrating, [39:34] zero
  output logic [3:0]  out_tuser,  // [3:0] out_key_index
  // Configuration port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int unsigned KEY_AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  // Configuration registers.
  logic [tkbt_pkg::BASE_W-1:0] threshold_r;
  logic [tkbt_pkg::AVG_W-1:0]  init_avg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= tkbt_pkg::THRESHOLD_RST;
      init_avg_r  <= tkbt_pkg::INIT_AVG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tkbt_pkg::REG_THRESHOLD: threshold_r <= cfg_wdata;
        tkbt_pkg::REG_INIT_AVG:  init_avg_r  <= cfg_wdata[tkbt_pkg::AVG_W-1:0];
        default: ;
      endcase
    end
  end

  // Input decode.
  logic [KEY_AW+tkbt_pkg::KEY_W-1:0] key_ext;
  logic [KEY_AW-1:0]                 in_addr;
  logic                              in_range;
  logic                              in_fire;

  assign key_ext  = {{KEY_AW{1'b0}}, in_tuser};
  assign in_addr  = key_ext[KEY_AW-1:0];
  assign in_range = ({28'd0, in_tuser} < 32'(NUM_KEYS));
  assign in_fire  = in_tvalid && in_tready;

  // Update stage registers.
  logic                        s1_valid_r;
  logic [tkbt_pkg::KEY_W-1:0]  s1_key_r;
  logic [KEY_AW-1:0]           s1_addr_r;
  logic [tkbt_pkg::BASE_W-1:0] s1_sample_r;
  logic                        s1_adv;

  logic                        out_valid_r;
  tkbt_pkg::result_t           out_res_r;
  logic [tkbt_pkg::KEY_W-1:0]  out_key_r;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  // Key memory, one entry per key, with a valid bit per entry so that an
  // entry never written since reset reads as zero.
  tkbt_pkg::entry_t mem [NUM_KEYS];
  tkbt_pkg::entry_t mem_rdata_r;
  logic [NUM_KEYS-1:0] valid_r;
  logic                rd_valid_r;

  // Bypass of the write that happens at the same edge as the read.
  tkbt_pkg::entry_t fwd_data_r;
  logic             use_fwd_r;

  tkbt_pkg::entry_t  cur_entry;
  tkbt_pkg::entry_t  nxt_entry;
  tkbt_pkg::result_t upd_res;

  always_comb begin
    priority if (use_fwd_r) begin
      cur_entry = fwd_data_r;
    end else if (rd_valid_r) begin
      cur_entry = mem_rdata_r;
    end else begin
      cur_entry = '0;
    end
  end

  tkbt_update u_update (
    .cur       (cur_entry),
    .sample    (s1_sample_r),
    .threshold (threshold_r),
    .init_avg  (init_avg_r),
    .nxt       (nxt_entry),
    .res       (upd_res)
  );

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      mem[s1_addr_r] <= nxt_entry;
    end
    if (in_fire) begin
      mem_rdata_r <= mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (s1_adv) begin
      valid_r[s1_addr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_valid_r  <= valid_r[in_addr];
      fwd_data_r  <= nxt_entry;
      s1_key_r    <= in_tuser;
      s1_addr_r   <= in_addr;
      s1_sample_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      use_fwd_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= in_range;
        use_fwd_r  <= s1_adv && (s1_addr_r == in_addr);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= upd_res;
      out_key_r <= s1_key_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_key_r;
  assign out_tdata  = {6'd0, out_res_r};

  // A key beyond the key count never reaches the update stage.
  a_drop_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_range) |=> !s1_valid_r)
    else $error("out-of-range key entered the update stage");

  // A calibration result carries no delta and no touch.
  a_calib_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.calibrating) |->
      (!out_res_r.touched && (out_res_r.key_delta == '0)))
    else $error("calibration result carries a delta or a touch");

  // The bypass is used only for an item in the update stage.
  a_fwd_live: assert property (@(posedge clk) disable iff (!rst_n)
    (use_fwd_r && !s1_valid_r) |-> !$past(in_fire))
    else $error("bypass armed without an item in the update stage");

  // Every update stage move lands a result in the output register.
  a_adv_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("update stage advanced without filling the output");

  // The calibration phase never counts beyond its bound.
  a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (cur_entry.phase <= tkbt_pkg::PHASE_W'(16)))
    else $error("key phase out of range");

endmodule

`default_nettype wire

FILE: bench/key_baseline_checker.sv
// Watches the tracker's channels, predicts each key update and checks the results.
module key_baseline_checker #(
  parameter int unsigned NUM_KEYS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic [3:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic [3:0]  out_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          outstanding,
  output int          failures
);

  typedef struct packed {
    logic [tkbt_pkg::KEY_W-1:0]  key;
    logic                        touched;
    logic [tkbt_pkg::BASE_W-1:0] delta;
    logic [tkbt_pkg::BASE_W-1:0] baseline;
    logic                        calibrating;
  } key_report_t;

  logic [tkbt_pkg::BASE_W-1:0]  touch_threshold;
  logic [tkbt_pkg::AVG_W-1:0]   avg_samples;
  logic [tkbt_pkg::BASE_W-1:0]  key_base [NUM_KEYS];
  logic [tkbt_pkg::PHASE_W-1:0] key_phase [NUM_KEYS];
  key_report_t                  reports_due [$];
  int                           fail_count = 0;

  // Applies one measurement to the tracked state of its key. Returns 0 when
  // the key lies outside the key memory, in which case nothing changes.
  function automatic bit track_measurement(input logic [tkbt_pkg::KEY_W-1:0] key,
                                           input logic [tkbt_pkg::BASE_W-1:0] count,
                                           output key_report_t rpt);
    logic [tkbt_pkg::BASE_W-1:0]  base;
    logic [tkbt_pkg::PHASE_W-1:0] phase;
    logic [tkbt_pkg::BASE_W:0]    raised;
    rpt = '0;
    rpt.key = key;
    if (key >= NUM_KEYS) return 1'b0;
    base  = key_base[key];
    phase = key_phase[key];
    if (phase == '0) begin
      base = count;
      phase = 5'd1;
      rpt.calibrating = 1'b1;
    end else if ((phase - 5'd1) < {1'b0, avg_samples}) begin
      base = (base >> 1) + (count >> 1);
      phase = phase + 5'd1;
      rpt.calibrating = 1'b1;
    end else begin
      if (count < base) begin
        rpt.delta = base - count;
      end else begin
        raised = {1'b0, base} + {1'b0, tkbt_pkg::RISE_STEP};
        base = (raised > {1'b0, tkbt_pkg::BASE_MAX}) ? tkbt_pkg::BASE_MAX
                                                     : raised[tkbt_pkg::BASE_W-1:0];
      end
      if (rpt.delta > touch_threshold) begin
        rpt.touched = 1'b1;
      end else if (base != '0) begin
        base = base - 16'd1;
      end
    end
    key_base[key]  = base;
    key_phase[key] = phase;
    rpt.baseline   = base;
    return 1'b1;
  endfunction

  function automatic int field_differs(input string name, input logic [3:0] key,
                                       input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("key %0d %s: expected %0h, actual %0h", key, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    key_report_t got;
    key_report_t want;
    if (!rst_n) begin
      touch_threshold = tkbt_pkg::THRESHOLD_RST;
      avg_samples     = tkbt_pkg::INIT_AVG_RST;
      for (int k = 0; k < NUM_KEYS; k++) begin
        key_base[k]  = '0;
        key_phase[k] = '0;
      end
      reports_due.delete();
    end else begin
      // A result leaving at this edge belongs to an item accepted at an earlier
      // edge, so it is checked before this edge's item is predicted.
      if (out_tvalid && out_tready) begin
        got.key         = out_tuser;
        got.touched     = out_tdata[0];
        got.delta       = out_tdata[16:1];
        got.baseline    = out_tdata[32:17];
        got.calibrating = out_tdata[33];
        if (reports_due.size() == 0) begin
          $error("result for key %0d with no item outstanding", got.key);
          fail_count++;
        end else begin
          want = reports_due.pop_front();
          fail_count += field_differs("out_key_index", want.key, 16'(want.key), 16'(got.key));
          fail_count += field_differs("touched", want.key, 16'(want.touched),
                                      16'(got.touched));
          fail_count += field_differs("key_delta", want.key, want.delta, got.delta);
          fail_count += field_differs("new_baseline", want.key, want.baseline, got.baseline);
          fail_count += field_differs("calibrating", want.key, 16'(want.calibrating),
                                      16'(got.calibrating));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          tkbt_pkg::REG_THRESHOLD: touch_threshold = cfg_wdata;
          tkbt_pkg::REG_INIT_AVG:  avg_samples = cfg_wdata[tkbt_pkg::AVG_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (track_measurement(in_tuser, in_tdata, want)) reports_due.push_back(want);
      end
    end
    outstanding <= reports_due.size();
    failures    <= fail_count;
  end

endmodule

FILE: bench/touch_key_baseline_tracker_core_test.sv
// Stimulus and verdict for the touch key baseline tracker core.
module touch_key_baseline_tracker_core_test;

  // The two register indexes that the block does not decode. Writes to them
  // must leave both registers untouched.
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  // Idling patterns of the scan phases.
  localparam int IDLE_NONE     = 0;
  localparam int IDLE_SENDER   = 1;
  localparam int IDLE_RECEIVER = 2;
  localparam int IDLE_BOTH     = 3;

  // Length of the long receiver hold-off that backs the pipeline up.
  localparam int HOLD_LEN = 80;
  // Far beyond the slowest legal run.
  localparam int RUN_LIMIT = 2_000_000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;    // [15:0] measured_count
  logic [3:0]  in_tuser;    // [3:0] key_index
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;   // [0] touched, [16:1] key_delta, [32:17] new_baseline,
                            // [33] calibrating, [39:34] zero
  logic [3:0]  out_tuser;   // [3:0] out_key_index
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  int outstanding;
  int failures;

  // Idling controls. The sender's share is only read by the stimulus process;
  // the receiver's share and the hold request are handed over with
  // nonblocking assignments so the receiver sees them after the current edge.
  int  sender_idle_pct;
  int  stall_pct;
  bit  long_hold;
  int  hold_cycles;

  // Current threshold, used to aim touch samples around the decision point.
  int  threshold_now;
  // Rough resting count of each key; most samples wander close to it.
  int  level [16];

  touch_key_baseline_tracker_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  key_baseline_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .outstanding (outstanding),
    .failures    (failures)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Absolute limit on the run. Reaching it means a result never came out.
  initial begin
    #(RUN_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Receiver. A requested long hold-off keeps out_tready low until hold_cycles,
  // counted here, reaches HOLD_LEN; otherwise ready drops at random at the current rate.
  always @(posedge clk) begin
    if (long_hold && hold_cycles < HOLD_LEN) begin
      out_tready  <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else begin
      if (!long_hold) hold_cycles <= 0;
      out_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [15:0] clamp_count(input int v);
    if (v < 0) return 16'h0000;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  // Offers one item, idling first at the sender's current rate, and returns
  // at the edge where the block takes it. tvalid stays high on return so that
  // back-to-back items need no second assignment in the same step.
  task automatic send_item(input logic [3:0] key, input logic [15:0] count);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= key;
    in_tdata  <= count;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Waits until every result has come back. The first edge lets the checker
  // count the last item.
  task automatic settle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers, with random bits above the averaging count's
  // field, and optionally pokes the two undecoded indexes as well.
  task automatic program_regs(input logic [15:0] thr_val, input logic [3:0] avg_val,
                              input bit poke_spare);
    logic [11:0] junk;
    junk = 12'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= tkbt_pkg::REG_THRESHOLD;
    cfg_wdata <= thr_val;
    @(posedge clk);
    cfg_index <= tkbt_pkg::REG_INIT_AVG;
    cfg_wdata <= {junk, avg_val};
    @(posedge clk);
    if (poke_spare) begin
      cfg_index <= REG_SPARE_A;
      cfg_wdata <= 16'($urandom);
      @(posedge clk);
      cfg_index <= REG_SPARE_B;
      cfg_wdata <= 16'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    threshold_now = thr_val;
  endtask

  // Picks the idling pattern of a phase: none, sender only, receiver only,
  // or both at a lighter rate.
  task automatic set_idling(input int mode);
    case (mode)
      IDLE_SENDER:   begin sender_idle_pct = 62; stall_pct <= 0;  end
      IDLE_RECEIVER: begin sender_idle_pct = 0;  stall_pct <= 62; end
      IDLE_BOTH:     begin sender_idle_pct = 19; stall_pct <= 19; end
      default:       begin sender_idle_pct = 0;  stall_pct <= 0;  end
    endcase
  endtask

  // A stretch of scanning. Most samples sit near the key's resting level,
  // many dip by roughly the threshold so touches fall on both sides of it,
  // and the rest are arbitrary counts or the extremes.
  task automatic run_scan(input int count);
    int k;
    int r;
    int spread;
    int v;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(15);
      r = $urandom_range(99);
      spread = (threshold_now > 2000) ? 2000 : threshold_now;
      if (r < 3) level[k] = $urandom_range(65535);
      if (r < 55) begin
        v = level[k] + int'($urandom_range(16)) - 8;
      end else if (r < 80) begin
        v = level[k] - int'($urandom_range(spread + spread / 2 + 20));
      end else if (r < 92) begin
        v = int'($urandom_range(65535));
      end else begin
        v = ($urandom_range(1) != 0) ? 65535 : 0;
      end
      send_item(4'(k), clamp_count(v));
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    // Every input known from time zero, with reset held active at the start.
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    out_tready <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= tkbt_pkg::REG_THRESHOLD;
    cfg_wdata  <= '0;
    long_hold  <= 1'b0;
    hold_cycles = 0;
    sender_idle_pct = 0;
    stall_pct <= 0;
    threshold_now = tkbt_pkg::THRESHOLD_RST;
    for (int k = 0; k < 16; k++) level[k] = $urandom_range(65535);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with the reset register values (threshold 100, four
    // averaging samples). Key 0 seeds at full scale and then runs into the
    // upper saturation on a rise; its items go back to back so each one reads
    // the entry the previous one is still writing.
    send_item(4'd0, 16'hFFFF);
    repeat (4) send_item(4'd0, 16'hFFFF);
    send_item(4'd0, 16'hFFFF);
    send_item(4'd0, 16'h0000);
    // Key 15 seeds at zero and then rises from a zero baseline.
    send_item(4'd15, 16'h0000);
    repeat (4) send_item(4'd15, 16'h0000);
    send_item(4'd15, 16'h0000);
    // Key 1 settles at 1000, then sees a delta equal to the threshold (no
    // touch, baseline drifts down) and one just above it (touch).
    send_item(4'd1, 16'd1000);
    repeat (4) send_item(4'd1, 16'd1000);
    send_item(4'd1, 16'd900);
    send_item(4'd1, 16'd898);
    in_tvalid <= 1'b0;
    settle();

    // Raising the averaging count to its maximum sends settled keys back
    // into averaging; the undecoded indexes are written at the same time.
    program_regs(16'd0, 4'd15, 1'b1);
    set_idling(IDLE_NONE);
    run_scan(95);
    settle();

    // Lowering it to zero ends averaging at once; nothing can be a touch.
    program_regs(16'hFFFF, 4'd0, 1'b0);
    set_idling(IDLE_SENDER);
    run_scan(95);
    settle();

    program_regs(16'($urandom_range(300, 20)), 4'($urandom_range(15)), 1'b1);
    set_idling(IDLE_RECEIVER);
    run_scan(95);
    settle();

    program_regs(tkbt_pkg::THRESHOLD_RST, tkbt_pkg::INIT_AVG_RST, 1'b0);
    set_idling(IDLE_BOTH);
    run_scan(95);
    settle();

    // Back-pressure: the receiver holds off for a long stretch while the
    // sender keeps offering, so the pipeline fills and in_tready falls.
    program_regs(16'($urandom_range(400)), 4'd2, 1'b0);
    set_idling(IDLE_NONE);
    long_hold <= 1'b1;
    run_scan(60);
    settle();
    long_hold <= 1'b0;

    program_regs(16'($urandom_range(500)), 4'd15, 1'b0);
    set_idling(IDLE_SENDER);
    run_scan(95);
    settle();

    program_regs(16'd1, 4'd0, 1'b1);
    set_idling(IDLE_RECEIVER);
    run_scan(95);
    settle();

    program_regs(16'($urandom_range(250)), 4'($urandom_range(15)), 1'b0);
    set_idling(IDLE_BOTH);
    run_scan(95);
    settle();

    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
